/* rtl/evr_pkg.sv */
package evr_pkg;

  // block-level widths, fixed for the whole design
  localparam int ANGLE_W = 16;
  localparam int COORD_W = 18;

  localparam int CORDIC_STEPS = 16;
  localparam int CW = 34;  // cordic datapath, q2.30 with headroom
  localparam int ZW = 18;  // residual phase
  localparam int TW = 17;  // trig values, q1.15 plus sign room for -sb
  localparam logic signed [CW-1:0] ONE_GAIN = 34'sd652032875;

  function automatic logic signed [ZW-1:0] atan_phase(input int i);
    case (i)
      0: atan_phase = 18'sd8192;
      1: atan_phase = 18'sd4836;
      2: atan_phase = 18'sd2555;
      3: atan_phase = 18'sd1297;
      4: atan_phase = 18'sd651;
      5: atan_phase = 18'sd326;
      6: atan_phase = 18'sd163;
      7: atan_phase = 18'sd81;
      8: atan_phase = 18'sd41;
      9: atan_phase = 18'sd20;
      10: atan_phase = 18'sd10;
      11: atan_phase = 18'sd5;
      12: atan_phase = 18'sd3;
      13: atan_phase = 18'sd1;
      14: atan_phase = 18'sd1;
      default: atan_phase = 18'sd0;
    endcase
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic flip;
  } cordic_t;

  typedef struct packed {
    logic signed [TW-1:0] s;
    logic signed [TW-1:0] c;
  } trig_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } out_t;

endpackage

/* rtl/evr_sincos.sv */
// pipelined cordic, one step per stage, advances on enable
module evr_sincos import evr_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output trig_t                        trig
);

  cordic_t st [0:CORDIC_STEPS];
  cordic_t init;
  logic [15:0] ph;
  logic signed [ZW-1:0] z0;
  logic signed [CW-1:0] xr, yr;
  logic signed [CW-16:0] xs, ys;

  always_comb begin
    if (ANGLE_BITS >= 16) ph = angle[ANGLE_BITS-1 -: 16];
    else ph = 16'({angle, {(16 - ANGLE_BITS){1'b0}}});
    z0 = ZW'($signed(ph));
    init.x = ONE_GAIN;
    init.y = '0;
    init.flip = 1'b0;
    if (z0 > 18'sd16384) begin
      init.z = z0 - 18'sd32768;
      init.flip = 1'b1;
    end else if (z0 < -18'sd16384) begin
      init.z = z0 + 18'sd32768;
      init.flip = 1'b1;
    end else begin
      init.z = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) st[0] <= init;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1].flip <= st[i].flip;
        if (!st[i].z[ZW-1]) begin
          st[i+1].x <= st[i].x - (st[i].y >>> i);
          st[i+1].y <= st[i].y + (st[i].x >>> i);
          st[i+1].z <= st[i].z - atan_phase(i);
        end else begin
          st[i+1].x <= st[i].x + (st[i].y >>> i);
          st[i+1].y <= st[i].y - (st[i].x >>> i);
          st[i+1].z <= st[i].z + atan_phase(i);
        end
      end
    end
  end

  always_comb begin
    xr = st[CORDIC_STEPS].flip ? -st[CORDIC_STEPS].x : st[CORDIC_STEPS].x;
    yr = st[CORDIC_STEPS].flip ? -st[CORDIC_STEPS].y : st[CORDIC_STEPS].y;
    xs = (CW-15)'((xr + 34'sd16384) >>> 15);
    ys = (CW-15)'((yr + 34'sd16384) >>> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig.c <= (xs > 32767) ? 17'sd32767 : (xs < -32768) ? -17'sd32768 : TW'(xs);
      trig.s <= (ys > 32767) ? 17'sd32767 : (ys < -32768) ? -17'sd32768 : TW'(ys);
    end
  end

endmodule

/* rtl/evr_matrix.sv */
// matrix build and matrix-vector product, registered after every multiply
module evr_matrix import evr_pkg::*; #(
  parameter int COORD_BITS = 18
) (
  input  logic                         clk,
  input  logic                         en,
  input  trig_t                        ta,
  input  trig_t                        tb,
  input  trig_t                        tc,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic signed [COORD_BITS-1:0] vz,
  output logic signed [COORD_BITS-1:0] ox,
  output logic signed [COORD_BITS-1:0] oy,
  output logic signed [COORD_BITS-1:0] oz
);

  localparam int RW = 19;               // matrix entries
  localparam int PW = RW + COORD_BITS;  // one product
  localparam int AW = PW + 2;           // row sum

  function automatic logic signed [TW-1:0] m15(input logic signed [TW-1:0] p,
                                               input logic signed [TW-1:0] q);
    logic signed [2*TW-1:0] r;
    r = (p * q + 34'sd16384) >>> 15;
    m15 = TW'(r);
  endfunction

  // stage a: pair products
  logic signed [TW-1:0] ca_sb, sa_sb, sa_cc, sa_sc, ca_cc, ca_sc, ca_cb, sa_cb, cb_sc, cb_cc;
  logic signed [TW-1:0] sc_a, cc_a, msb_a;
  logic signed [COORD_BITS-1:0] v0 [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      ca_sb <= m15(ta.c, tb.s); sa_sb <= m15(ta.s, tb.s);
      sa_cc <= m15(ta.s, tc.c); sa_sc <= m15(ta.s, tc.s);
      ca_cc <= m15(ta.c, tc.c); ca_sc <= m15(ta.c, tc.s);
      ca_cb <= m15(ta.c, tb.c); sa_cb <= m15(ta.s, tb.c);
      cb_sc <= m15(tb.c, tc.s); cb_cc <= m15(tb.c, tc.c);
      sc_a <= tc.s; cc_a <= tc.c; msb_a <= -tb.s;
      v0[0] <= vx; v0[1] <= vy; v0[2] <= vz;
    end
  end

  // stage b: triple products and entries
  logic signed [RW-1:0] r [0:8];
  logic signed [COORD_BITS-1:0] v1 [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= RW'(ca_cb);
      r[1] <= RW'(m15(ca_sb, sc_a)) - RW'(sa_cc);
      r[2] <= RW'(m15(ca_sb, cc_a)) + RW'(sa_sc);
      r[3] <= RW'(sa_cb);
      r[4] <= RW'(m15(sa_sb, sc_a)) + RW'(ca_cc);
      r[5] <= RW'(m15(sa_sb, cc_a)) - RW'(ca_sc);
      r[6] <= RW'(msb_a);
      r[7] <= RW'(cb_sc);
      r[8] <= RW'(cb_cc);
      v1 <= v0;
    end
  end

  // stage c: nine products
  logic signed [PW-1:0] p [0:8];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) p[k] <= PW'(r[k] * v1[k%3]);
    end
  end

  // stage d: row sums, round and saturate
  logic signed [AW-1:0] acc [0:2];
  logic signed [AW-16:0] sh [0:2];
  logic signed [COORD_BITS-1:0] res [0:2];
  localparam logic signed [AW-16:0] HI = (AW-15)'((64'sd1 <<< (COORD_BITS-1)) - 1);
  localparam logic signed [AW-16:0] LO = -HI - 1;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = AW'(p[3*k]) + AW'(p[3*k+1]) + AW'(p[3*k+2]) + AW'(16384);
      sh[k] = (AW-15)'(acc[k] >>> 15);
      res[k] = (sh[k] > HI) ? COORD_BITS'(HI) : (sh[k] < LO) ? COORD_BITS'(LO)
               : COORD_BITS'(sh[k]);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ox <= res[0]; oy <= res[1]; oz <= res[2];
    end
  end

endmodule

/* rtl/euler_vector_rotate_top.sv */
// channel | direction | payload          | handshake
// in      | input     | in_data (in_t)   | in_valid / in_ready
// out     | output    | out_data (out_t) | out_valid / out_ready
// one item per cycle while the output is not stalled; the pipeline is 17 cordic
// stages, a trig register and four matrix stages
// rst clears only the valid bits; data registers need no reset
// the whole pipeline advances when the last stage is empty or taken, so a
// stall holds every item in place and nothing is lost or repeated
module euler_vector_rotate_top import evr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int TRIG_LAT = CORDIC_STEPS + 2;
  localparam int LAT = TRIG_LAT + 4;

  logic en;
  logic [LAT-1:0] vld;
  logic signed [COORD_W-1:0] dx [0:TRIG_LAT-1];
  logic signed [COORD_W-1:0] dy [0:TRIG_LAT-1];
  logic signed [COORD_W-1:0] dz [0:TRIG_LAT-1];
  logic signed [COORD_W-1:0] ox, oy, oz;
  trig_t ta, tb, tc;

  assign en = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];
  assign out_data = {ox, oy, oz};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // vector rides alongside the cordic pipes
  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= in_data.in_x; dy[0] <= in_data.in_y; dz[0] <= in_data.in_z;
      for (int k = 1; k < TRIG_LAT; k++) begin
        dx[k] <= dx[k-1]; dy[k] <= dy[k-1]; dz[k] <= dz[k-1];
      end
    end
  end

  evr_sincos #(.ANGLE_BITS(ANGLE_W)) u_yaw (.clk, .en, .angle(in_data.yaw_angle), .trig(ta));
  evr_sincos #(.ANGLE_BITS(ANGLE_W)) u_pitch (.clk, .en, .angle(in_data.pitch_angle), .trig(tb));
  evr_sincos #(.ANGLE_BITS(ANGLE_W)) u_roll (.clk, .en, .angle(in_data.roll_angle), .trig(tc));

  evr_matrix #(.COORD_BITS(COORD_W)) u_mat (
    .clk, .en, .ta, .tb, .tc,
    .vx(dx[TRIG_LAT-1]), .vy(dy[TRIG_LAT-1]), .vz(dz[TRIG_LAT-1]),
    .ox, .oy, .oz
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result moved while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("empty pipe refused an item");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("valid bits moved during stall");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

/* verif/tb_top.sv */
module tb_top;
  import evr_pkg::*;

  localparam int AB = ANGLE_W;
  localparam int CB = COORD_W;
  localparam int LATENCY = 22;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } vec_t;

  // rounded fixed-point helpers for the rotation predictor
  function automatic longint asr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd15(longint v);
    return asr_floor(v + (64'sd1 <<< 14), 15);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void angle_trig(logic [AB-1:0] a, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    int k;
    longint tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                         41, 20, 10, 5, 3, 1, 1, 0};
    z = longint'($signed(a));
    flip = 0;
    x = 652032875;
    y = 0;
    if (z > 16384) begin
      z -= 32768;
      flip = 1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1;
    end
    for (k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= tab[k];
      end else begin
        x += dx;
        y -= dy;
        z += tab[k];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp(rnd15(x), -32768, 32767);
    s = clamp(rnd15(y), -32768, 32767);
  endfunction

  function automatic vec_t rotate_vector(logic [AB-1:0] ya, logic [AB-1:0] pa,
                                         logic [AB-1:0] ra, logic signed [CB-1:0] vx,
                                         logic signed [CB-1:0] vy, logic signed [CB-1:0] vz);
    longint sa, ca, sb, cb, sc, cc;
    longint m [3][3];
    longint v [3];
    longint acc, lo, hi;
    vec_t res;
    angle_trig(ya, sa, ca);
    angle_trig(pa, sb, cb);
    angle_trig(ra, sc, cc);
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    m[0][0] = rnd15(ca * cb);
    m[0][1] = rnd15(rnd15(ca * sb) * sc) - rnd15(sa * cc);
    m[0][2] = rnd15(rnd15(ca * sb) * cc) + rnd15(sa * sc);
    m[1][0] = rnd15(sa * cb);
    m[1][1] = rnd15(rnd15(sa * sb) * sc) + rnd15(ca * cc);
    m[1][2] = rnd15(rnd15(sa * sb) * cc) - rnd15(ca * sc);
    m[2][0] = -sb;
    m[2][1] = rnd15(cb * sc);
    m[2][2] = rnd15(cb * cc);
    lo = -(64'sd1 <<< (CB - 1));
    hi = (64'sd1 <<< (CB - 1)) - 1;
    acc = m[0][0] * v[0] + m[0][1] * v[1] + m[0][2] * v[2];
    res.x = CB'(clamp(rnd15(acc), lo, hi));
    acc = m[1][0] * v[0] + m[1][1] * v[1] + m[1][2] * v[2];
    res.y = CB'(clamp(rnd15(acc), lo, hi));
    acc = m[2][0] * v[0] + m[2][1] * v[1] + m[2][2] * v[2];
    res.z = CB'(clamp(rnd15(acc), lo, hi));
    return res;
  endfunction

  class rotation_scoreboard;
    vec_t pending [$];
    int errors = 0;

    function void note_input(logic [AB-1:0] ya, logic [AB-1:0] pa, logic [AB-1:0] ra,
                             logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
                             logic signed [CB-1:0] vz);
      pending.insert(pending.size(), rotate_vector(ya, pa, ra, vx, vy, vz));
    endfunction

    function void check_result(logic signed [CB-1:0] rx, logic signed [CB-1:0] ry,
                               logic signed [CB-1:0] rz);
      vec_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item out (%0d %0d %0d)", $time, rx, ry, rz);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rx !== e.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.x, rx);
        errors++;
      end
      if (ry !== e.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.y, ry);
        errors++;
      end
      if (rz !== e.z) begin
        $display("%0t: out_z expected %0d actual %0d", $time, e.z, rz);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [AB-1:0] yaw_angle, pitch_angle, roll_angle;
  logic signed [CB-1:0] in_x, in_y, in_z, out_x, out_y, out_z;
  in_t in_data;
  out_t out_data;

  rotation_scoreboard board;
  int cycles = 0;
  bit hold_off = 0;

  assign in_data = {yaw_angle, pitch_angle, roll_angle, in_x, in_y, in_z};
  assign {out_x, out_y, out_z} = out_data;

  euler_vector_rotate_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // sample both channels at the edge, before the testbench drives anything new
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && in_ready)
      board.note_input(yaw_angle, pitch_angle, roll_angle, in_x, in_y, in_z);
    if (!rst && out_valid && out_ready)
      board.check_result(out_x, out_y, out_z);
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall pattern with periodic always-ready windows, long hold-off on request
  always @(posedge clk) begin
    if (rst)
      out_ready <= 0;
    else if (hold_off)
      out_ready <= 0;
    else if (cycles % 512 < 64)
      out_ready <= 1;
    else
      out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_item(logic [AB-1:0] ya, logic [AB-1:0] pa, logic [AB-1:0] ra,
                           logic [CB-1:0] vx, logic [CB-1:0] vy, logic [CB-1:0] vz);
    in_valid <= 1;
    yaw_angle <= ya;
    pitch_angle <= pa;
    roll_angle <= ra;
    in_x <= vx;
    in_y <= vy;
    in_z <= vz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [CB-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CB-1){1'b1}}};
      1: return {1'b1, {(CB-1){1'b0}}};
      2: return CB'($signed($urandom_range(0, 16383)) - 8192);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [AB-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return AB'(16'h4000 + $urandom_range(0, 4) - 2);
      default: return AB'($urandom);
    endcase
  endfunction

  task automatic random_burst(int n);
    int k;
    for (k = 0; k < n; k++) begin
      send_item(pick_angle(), pick_angle(), pick_angle(),
                pick_coord(), pick_coord(), pick_coord());
      if ($urandom_range(0, 9) == 0 && k != n - 1) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  initial begin
    int sent, n, a;
    board = new();
    rst = 1;
    in_valid = 0;
    yaw_angle = 0;
    pitch_angle = 0;
    roll_angle = 0;
    in_x = 0;
    in_y = 0;
    in_z = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: identity, quarter turns, half turns, angle extremes, full-scale vectors
    send_item(0, 0, 0, 8192, -8192, 1);
    send_item(16'h4000, 0, 0, 8192, 0, 0);
    send_item(0, 16'h4000, 0, 0, 0, 8192);
    send_item(0, 0, 16'h4000, 0, 8192, 0);
    send_item(16'h8000, 16'h8000, 16'h8000, CMAX, CMIN, CMAX);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, CMIN, CMIN, CMIN);
    send_item(16'hC000, 16'hC000, 16'hC000, CMAX, CMAX, CMAX);
    send_item(16'h4001, 16'hBFFF, 16'h3FFF, CMIN, CMAX, CMIN);
    send_item(16'h2000, 16'h2000, 16'h2000, CMAX, CMAX, CMAX);
    send_item(16'hE000, 16'h6000, 16'hA000, CMIN, CMIN, CMAX);
    send_item(16'hFFFF, 16'h0001, 16'h8001, -1, 1, 0);
    send_item(16'h5555, 16'hAAAA, 16'h1234, 18'h2AAAA, 18'h15555, 18'h3FFFF);
    go_idle();
    // sender pauses until the pipe has drained
    wait_drained();
    repeat (4) @(posedge clk);

    sent = 0;
    while (sent < 1700) begin
      n = $urandom_range(1, 40);
      if (sent < 200 && sent + n >= 200) begin
        // long receiver hold-off while items keep coming, fills the pipeline
        hold_off = 1;
        fork
          begin
            repeat (3 * LATENCY + 40) @(posedge clk);
            hold_off = 0;
          end
          random_burst(3 * LATENCY);
        join
        sent += 3 * LATENCY;
      end
      random_burst(n);
      sent += n;
      a = $urandom_range(0, 3);
      if (a == 0) begin
        go_idle();
        repeat ($urandom_range(0, 30)) @(posedge clk);
      end else if (a == 1) begin
        go_idle();
      end
    end
    go_idle();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
